[sv/ttc_pkg.sv]
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared types and codes of the thermal throttle controller.
// ----------------------------------------------------------------------------
package ttc_pkg;

	// Throttle levels
	typedef logic [1:0] level_t;
	localparam level_t LVL_NORMAL   = 2'd0;
	localparam level_t LVL_LIGHT    = 2'd1;
	localparam level_t LVL_SEVERE   = 2'd2;
	localparam level_t LVL_SHUTDOWN = 2'd3;

	// Item operations; the unused code behaves as a tick
	typedef logic [1:0] op_t;
	localparam op_t OP_SAMPLE = 2'd0;
	localparam op_t OP_TICK   = 2'd1;
	localparam op_t OP_ADMIT  = 2'd2;

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;
	typedef logic [CFG_IDX_BITS-1:0] reg_idx_t;
	localparam reg_idx_t REG_LIGHT_THR    = 3'd0;
	localparam reg_idx_t REG_SEVERE_THR   = 3'd1;
	localparam reg_idx_t REG_SHUTDOWN_THR = 3'd2;
	localparam reg_idx_t REG_HYST_BAND    = 3'd3;
	localparam reg_idx_t REG_ACTION_DELAY = 3'd4;
	localparam reg_idx_t REG_MIN_DWELL    = 3'd5;
	localparam reg_idx_t REG_LIGHT_GAP    = 3'd6;
	localparam reg_idx_t REG_POLICY_EN    = 3'd7;

	localparam int THR_BITS = 16;
	localparam int DLY_BITS = 32;

	typedef struct packed {
		logic [THR_BITS-1:0] light_thr;
		logic [THR_BITS-1:0] severe_thr;
		logic [THR_BITS-1:0] shutdown_thr;
		logic [THR_BITS-1:0] hyst_band;
		logic [DLY_BITS-1:0] action_delay;
		logic [DLY_BITS-1:0] min_dwell;
		logic [DLY_BITS-1:0] light_gap;
		logic                policy_en;
	} cfg_t;

	// Level bookkeeping carried between items
	typedef struct packed {
		level_t applied;
		level_t suggested;
		logic   pend_v;
		level_t pend_lvl;
	} ctl_t;

	// One result item
	typedef struct packed {
		level_t applied_level;
		level_t suggested_level;
		logic   admit;
		logic   level_changed;
		logic   change_pending;
	} res_t;

endpackage

[sv/ttc_item_if.sv]
// ----------------------------------------------------------------------------
// ttc_item_if
// Input item channel: valid/ready handshake with sample/tick/admit payload.
// ----------------------------------------------------------------------------
interface ttc_item_if #(
	parameter int TIME_BITS = 48,
	parameter int TEMP_BITS = 16
);
	logic                 valid;
	logic                 ready;
	ttc_pkg::op_t         operation;
	logic [TIME_BITS-1:0] time_ns;
	logic [TEMP_BITS-1:0] temperature;
	logic                 is_maintenance;

	modport source (
		output valid, operation, time_ns, temperature, is_maintenance,
		input  ready
	);
	modport sink (
		input  valid, operation, time_ns, temperature, is_maintenance,
		output ready
	);
endinterface

[sv/ttc_result_if.sv]
// ----------------------------------------------------------------------------
// ttc_result_if
// Result item channel: valid/ready handshake with throttle status payload.
// ----------------------------------------------------------------------------
interface ttc_result_if;
	logic                 valid;
	logic                 ready;
	ttc_pkg::level_t      applied_level;
	ttc_pkg::level_t      suggested_level;
	logic                 admit;
	logic                 level_changed;
	logic                 change_pending;

	modport source (
		output valid, applied_level, suggested_level, admit, level_changed,
		       change_pending,
		input  ready
	);
	modport sink (
		input  valid, applied_level, suggested_level, admit, level_changed,
		       change_pending,
		output ready
	);
endinterface

[sv/ttc_cfg.sv]
// ----------------------------------------------------------------------------
// ttc_cfg
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module ttc_cfg #(
	parameter int TEMP_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               we,
	input  ttc_pkg::reg_idx_t                  index,
	input  logic [ttc_pkg::CFG_DATA_BITS-1:0]  data,
	output ttc_pkg::cfg_t                      cfg
);
	// thresholds keep no more bits than a temperature has
	localparam logic [ttc_pkg::THR_BITS-1:0] THR_MASK =
		(TEMP_BITS >= ttc_pkg::THR_BITS) ? {ttc_pkg::THR_BITS{1'b1}} :
		ttc_pkg::THR_BITS'((64'd1 << TEMP_BITS) - 64'd1);

	ttc_pkg::cfg_t cfg_q;
	logic [ttc_pkg::THR_BITS-1:0] thr_wr;

	assign thr_wr = data[ttc_pkg::THR_BITS-1:0] & THR_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_thr    <= 16'd5680;
			cfg_q.severe_thr   <= 16'd5840;
			cfg_q.shutdown_thr <= 16'd6000;
			cfg_q.hyst_band    <= 16'd32;
			cfg_q.action_delay <= 32'd0;
			cfg_q.min_dwell    <= 32'd0;
			cfg_q.light_gap    <= 32'd1000;
			cfg_q.policy_en    <= 1'b1;
		end else if (we) begin
			case (index)
				ttc_pkg::REG_LIGHT_THR:    cfg_q.light_thr    <= thr_wr;
				ttc_pkg::REG_SEVERE_THR:   cfg_q.severe_thr   <= thr_wr;
				ttc_pkg::REG_SHUTDOWN_THR: cfg_q.shutdown_thr <= thr_wr;
				ttc_pkg::REG_HYST_BAND:    cfg_q.hyst_band    <= data[ttc_pkg::THR_BITS-1:0];
				ttc_pkg::REG_ACTION_DELAY: cfg_q.action_delay <= data;
				ttc_pkg::REG_MIN_DWELL:    cfg_q.min_dwell    <= data;
				ttc_pkg::REG_LIGHT_GAP:    cfg_q.light_gap    <= data;
				ttc_pkg::REG_POLICY_EN:    cfg_q.policy_en    <= data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/ttc_step.sv]
// ----------------------------------------------------------------------------
// ttc_step
// Next-state and result logic for one item: due-change apply, threshold
// sampling with hysteresis, change scheduling and admission control.
// ----------------------------------------------------------------------------
module ttc_step #(
	parameter int TIME_BITS = 48,
	parameter int TEMP_BITS = 16
) (
	input  ttc_pkg::cfg_t         cfg,
	input  ttc_pkg::ctl_t         ctl_cur,
	input  logic [TIME_BITS-1:0]  lct_cur,
	input  logic [TIME_BITS-1:0]  nat_cur,
	input  logic [TIME_BITS-1:0]  due_cur,
	input  ttc_pkg::op_t          op,
	input  logic [TIME_BITS-1:0]  now,
	input  logic [TEMP_BITS-1:0]  temp,
	input  logic                  maint,
	output ttc_pkg::ctl_t         ctl_nxt,
	output logic [TIME_BITS-1:0]  lct_nxt,
	output logic [TIME_BITS-1:0]  nat_nxt,
	output logic [TIME_BITS-1:0]  due_nxt,
	output ttc_pkg::res_t         res
);
	localparam int SW = TIME_BITS + 1;
	localparam int CW = (TEMP_BITS > ttc_pkg::THR_BITS) ? TEMP_BITS : ttc_pkg::THR_BITS;
	localparam int HW = CW + 1;

	function automatic logic [TIME_BITS-1:0] sat_add(
		input logic [TIME_BITS-1:0]          a,
		input logic [ttc_pkg::DLY_BITS-1:0]  b
	);
		logic [SW-1:0] s;
		s = {1'b0, a} + SW'(b);
		return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
	endfunction

	logic [CW-1:0]           temp_x;
	logic [CW-1:0]           thr_app;
	logic [1:0]              cnt;
	logic                    hold;
	ttc_pkg::level_t         desired;
	logic [TIME_BITS-1:0]    due_a;
	logic [TIME_BITS-1:0]    due_b;
	logic                    due1;
	logic                    due2;
	logic                    blocked;

	always_comb begin
		ctl_nxt = ctl_cur;
		lct_nxt = lct_cur;
		nat_nxt = nat_cur;
		due_nxt = due_cur;
		res     = '0;
		due2    = 1'b0;
		blocked = 1'b0;

		// a change that has come due applies before anything else
		due1 = ctl_cur.pend_v && (due_cur <= now);
		if (due1) begin
			ctl_nxt.applied = ctl_cur.pend_lvl;
			ctl_nxt.pend_v  = 1'b0;
			lct_nxt         = now;
		end

		temp_x = CW'(temp);
		cnt = 2'(temp_x >= CW'(cfg.light_thr)) + 2'(temp_x >= CW'(cfg.severe_thr))
		    + 2'(temp_x >= CW'(cfg.shutdown_thr));

		case (ctl_nxt.applied)
			ttc_pkg::LVL_LIGHT:  thr_app = CW'(cfg.light_thr);
			ttc_pkg::LVL_SEVERE: thr_app = CW'(cfg.severe_thr);
			default:             thr_app = CW'(cfg.shutdown_thr);
		endcase
		hold = (HW'(temp_x) + HW'(cfg.hyst_band)) >= HW'(thr_app);

		// drop below the applied level is held inside the band
		desired = (cnt < ctl_nxt.applied && hold) ? ctl_nxt.applied : cnt;

		due_a = sat_add(now, cfg.action_delay);
		due_b = sat_add(lct_nxt, cfg.min_dwell);

		case (op)
			ttc_pkg::OP_SAMPLE: begin
				ctl_nxt.suggested = desired;
				if (cfg.policy_en) begin
					if (desired == ctl_nxt.applied) begin
						ctl_nxt.pend_v = 1'b0;
					end else if (!ctl_nxt.pend_v || ctl_nxt.pend_lvl != desired) begin
						ctl_nxt.pend_v   = 1'b1;
						ctl_nxt.pend_lvl = desired;
						due_nxt          = (due_a > due_b) ? due_a : due_b;
					end
				end
				// a freshly scheduled change may already be due
				due2 = ctl_nxt.pend_v && (due_nxt <= now);
				if (due2) begin
					ctl_nxt.applied = ctl_nxt.pend_lvl;
					ctl_nxt.pend_v  = 1'b0;
					lct_nxt         = now;
				end
			end
			ttc_pkg::OP_ADMIT: begin
				blocked = (ctl_nxt.applied == ttc_pkg::LVL_SHUTDOWN) ||
					(!maint && (ctl_nxt.applied >= ttc_pkg::LVL_SEVERE ||
					 (ctl_nxt.applied == ttc_pkg::LVL_LIGHT && now < nat_cur)));
				res.admit = !blocked;
				if (!blocked && !maint && ctl_nxt.applied == ttc_pkg::LVL_LIGHT) begin
					nat_nxt = sat_add(now, cfg.light_gap);
				end
			end
			default: ;
		endcase

		res.applied_level   = ctl_nxt.applied;
		res.suggested_level = ctl_nxt.suggested;
		res.level_changed   = due1 || due2;
		res.change_pending  = ctl_nxt.pend_v;
	end

endmodule

[sv/thermal_throttle_controller_unit.sv]
// ----------------------------------------------------------------------------
// thermal_throttle_controller_unit
// Pipeline: two register stages; an item is held in the input register and
// its result in the result register. One item per cycle while the result
// channel is not stalled; input register, one level of step logic and the
// result register, with the level state updated in the same cycle.
// Reset: configuration registers return to their defaults, level state
// clears to Normal with nothing pending, and both pipeline stages empty.
// ----------------------------------------------------------------------------
module thermal_throttle_controller_unit #(
	parameter int TIME_BITS = 48,
	parameter int TEMP_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  ttc_pkg::reg_idx_t                  cfg_index,
	input  logic [ttc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	ttc_item_if.sink                           item,
	ttc_result_if.source                       result
);
	ttc_pkg::cfg_t         cfg;

	logic                  v_s1;
	ttc_pkg::op_t          op_s1;
	logic [TIME_BITS-1:0]  time_s1;
	logic [TEMP_BITS-1:0]  temp_s1;
	logic                  maint_s1;

	logic                  v_s2;
	ttc_pkg::res_t         res_s2;

	ttc_pkg::ctl_t         ctl_q;
	logic [TIME_BITS-1:0]  lct_q;
	logic [TIME_BITS-1:0]  nat_q;
	logic [TIME_BITS-1:0]  due_q;

	ttc_pkg::ctl_t         ctl_nxt;
	logic [TIME_BITS-1:0]  lct_nxt;
	logic [TIME_BITS-1:0]  nat_nxt;
	logic [TIME_BITS-1:0]  due_nxt;
	ttc_pkg::res_t         res_nxt;

	logic                  adv;
	logic                  proc_s1;

	ttc_cfg #(.TEMP_BITS(TEMP_BITS)) u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.index (cfg_index),
		.data  (cfg_data),
		.cfg   (cfg)
	);

	ttc_step #(.TIME_BITS(TIME_BITS), .TEMP_BITS(TEMP_BITS)) u_step (
		.cfg    (cfg),
		.ctl_cur(ctl_q),
		.lct_cur(lct_q),
		.nat_cur(nat_q),
		.due_cur(due_q),
		.op     (op_s1),
		.now    (time_s1),
		.temp   (temp_s1),
		.maint  (maint_s1),
		.ctl_nxt(ctl_nxt),
		.lct_nxt(lct_nxt),
		.nat_nxt(nat_nxt),
		.due_nxt(due_nxt),
		.res    (res_nxt)
	);

	// stage 1 moves on when the result register is empty or being drained
	assign adv        = !v_s2 || result.ready;
	assign proc_s1    = v_s1 && adv;
	assign item.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item.ready) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1    <= item.operation;
			time_s1  <= item.time_ns;
			temp_s1  <= item.temperature;
			maint_s1 <= item.is_maintenance;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1) begin
			res_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '{applied: ttc_pkg::LVL_NORMAL, suggested: ttc_pkg::LVL_NORMAL,
			           pend_v: 1'b0, pend_lvl: ttc_pkg::LVL_NORMAL};
			lct_q <= '0;
			nat_q <= '0;
			due_q <= '0;
		end else if (proc_s1) begin
			ctl_q <= ctl_nxt;
			lct_q <= lct_nxt;
			nat_q <= nat_nxt;
			due_q <= due_nxt;
		end
	end

	assign result.valid           = v_s2;
	assign result.applied_level   = res_s2.applied_level;
	assign result.suggested_level = res_s2.suggested_level;
	assign result.admit           = res_s2.admit;
	assign result.level_changed   = res_s2.level_changed;
	assign result.change_pending  = res_s2.change_pending;

`ifndef SYNTH
	// a waiting change always targets a level other than the applied one
	a_pend_differs: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.pend_v |-> (ctl_q.pend_lvl != ctl_q.applied))
		else $error("pending level equals applied level");

	// a move of the applied level is always flagged; two changes in one item
	// can land back on the old level, so the flag alone proves nothing
	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		proc_s1 |=> ((ctl_q.applied == $past(ctl_q.applied)) || res_s2.level_changed))
		else $error("level_changed disagrees with applied level");

	// level state moves only when an item is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!proc_s1 |=> $stable(ctl_q))
		else $error("level state changed without an item");

	// nothing is admitted at Shutdown
	a_no_admit_shutdown: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && res_s2.admit) |-> (res_s2.applied_level != ttc_pkg::LVL_SHUTDOWN))
		else $error("admission granted at shutdown");
`endif

endmodule
